>>> hdl/smt_pkg.sv
package smt_pkg;

   // Number of table entries, one per cell in the chain.
   localparam int CAPACITY        = 256;
   // Width of an occurrence count inside the table.
   localparam int COUNT_BITS      = 16;
   // Width of the count reported on the result channel.
   localparam int BEST_COUNT_BITS = 16;
   localparam int SAMPLE_BITS     = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          start_req;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]   best_sample;
      logic        [BEST_COUNT_BITS-1:0] best_count;
      logic                            table_full;
   } rsp_type;

   // What one cell hands to its neighbor: a request on its way down the chain.
   typedef struct packed {
      logic                    valid;
      logic                    start;
      logic                    found;
      logic [SAMPLE_BITS-1:0]  sample;
      logic [COUNT_BITS-1:0]   count;
   } smt_link_type;

endpackage

>>> hdl/streaming_mode_tracker.sv
// Running mode tracker. Each request carries one signed 32-bit sample and a
// start flag; each request yields exactly one response with the most frequent
// sample so far, its saturating count, and a flag that says the sample was new
// and was dropped because all CAPACITY table entries were in use.
// The table is a chain of CAPACITY cells, each holding one entry. A request
// walks down the chain one cell per cycle whenever the chain advances, so
// requests follow one another in consecutive cycles: one request per cycle is
// accepted while req_stall is low, and its response is registered by the
// leader stage at the tail once it has passed the whole cell chain.
// A start request empties each cell as it passes it and clears the leader, so
// the requests behind it see a fresh table.
// Reset clears every entry's valid bit, the leader and all in-flight requests
// at once; the block takes requests in the first cycle after reset.
// When the receiver stalls with a response waiting, the whole chain holds and
// req_stall goes high; nothing moves and nothing is lost until the stall lifts.
module streaming_mode_tracker
   import smt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // The chain advances whenever the output register is free or being emptied.
   logic         adv;
   smt_link_type link [0:CAPACITY];

   assign adv       = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~adv;

   // The head of the chain sees the request port directly; a request enters
   // the first cell on the edge at which it is accepted.
   assign link[0] = '{valid:  req_valid & adv,
                      start:  req_data.start_req,
                      found:  1'b0,
                      sample: req_data.sample,
                      count:  '0};

   // Each cell compares the passing sample with its entry, bumps its count on
   // a match, or claims the sample if it is the first empty cell reached.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      smt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .link_in  (link[g]),
         .link_out (link[g+1])
      );
   end

   // The tail keeps the leader and registers the response. A request that
   // leaves the chain unmatched was dropped for lack of space.
   smt_leader u_leader (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .link_in   (link[CAPACITY]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/smt_cell.sv
module smt_cell
   import smt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  smt_link_type link_in,
   output smt_link_type link_out
);

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] key_ff, key_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   smt_link_type           link_ff, link_in_next;

   logic                   eff_valid;
   logic                   hit;
   logic                   ins;
   logic [COUNT_BITS-1:0]  inc_count;

   // A start request empties the entry as it passes, before it is looked at.
   // Entries fill in chain order, so the first empty cell that a request
   // reaches unmatched is where its sample goes.
   always_comb begin
      eff_valid = valid_ff & ~link_in.start;
      hit       = link_in.valid & ~link_in.found & eff_valid & (key_ff == link_in.sample);
      ins       = link_in.valid & ~link_in.found & ~eff_valid;
      inc_count = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;

      valid_in = link_in.valid ? (eff_valid | ins) : valid_ff;
      key_in   = ins ? link_in.sample : key_ff;
      count_in = ins ? COUNT_ONE : (hit ? inc_count : count_ff);

      link_in_next       = link_in;
      link_in_next.found = link_in.found | hit | ins;
      link_in_next.count = ins ? COUNT_ONE : (hit ? inc_count : link_in.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         link_ff.valid <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
         link_ff  <= link_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign link_out = link_ff;

endmodule

>>> hdl/smt_leader.sv
module smt_leader
   import smt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  smt_link_type link_in,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic [SAMPLE_BITS-1:0] leader_sample_ff, leader_sample_in;
   logic [COUNT_BITS-1:0]  leader_count_ff, leader_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [SAMPLE_BITS-1:0] base_sample;
   logic [COUNT_BITS-1:0]  base_count;
   logic                   take;

   // A strictly larger count takes the lead, so on a tie the earlier value stays.
   always_comb begin
      base_sample = link_in.start ? '0 : leader_sample_ff;
      base_count  = link_in.start ? '0 : leader_count_ff;
      take        = link_in.found & (link_in.count > base_count);

      leader_sample_in = take ? link_in.sample : base_sample;
      leader_count_in  = take ? link_in.count : base_count;

      rsp_valid_in           = link_in.valid;
      rsp_data_in.best_sample = leader_sample_in;
      rsp_data_in.best_count  = BEST_COUNT_BITS'(leader_count_in);
      rsp_data_in.table_full  = ~link_in.found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_sample_ff <= '0;
         leader_count_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
         if (link_in.valid) begin
            leader_sample_ff <= leader_sample_in;
            leader_count_ff  <= leader_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && link_in.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/smt_checker.sv
module smt_checker
   import smt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // With the output register empty the block always takes a request.
   a_take_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // A full table implies at least one sample was counted.
   a_full_has_leader: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> rsp_data.best_count != '0)
      else $error("table full without a leader");

   // A zero count leader is the zero value.
   a_zero_leader: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.best_count == '0) |-> rsp_data.best_sample == '0)
      else $error("zero count with nonzero leader");

endmodule

bind streaming_mode_tracker smt_checker u_smt_checker (.*);
